// File: hdl/sog_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the odd-only sieve and Goldbach pair engine.
package sog_pkg;

	localparam int unsigned SOG_MAX_LIMIT = 65536;
	localparam int unsigned SOG_WORD_BITS = 32;
	localparam int unsigned SOG_FIELD_W   = 16;
	// Sieving primes stay at or below sqrt(65535), so k never passes 257.
	localparam int unsigned SOG_K_W       = 9;
	localparam int unsigned SOG_MIN_QUERY = 6;
	localparam int unsigned SOG_FIRST_ODD = 3;

	typedef enum logic {
		KIND_BUILD,
		KIND_QUERY
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_BUILT,
		STATUS_PAIR,
		STATUS_NO_PAIR,
		STATUS_INVALID
	} status_t;

	typedef struct packed {
		kind_t                  kind;
		logic [SOG_FIELD_W-1:0] value;
	} item_t;

	typedef struct packed {
		status_t                status;
		logic [SOG_FIELD_W-1:0] count;
		logic [SOG_FIELD_W-1:0] smaller_addend;
		logic [SOG_FIELD_W-1:0] larger_addend;
	} result_t;

endpackage

// File: hdl/sog_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one payload of a given type.
interface sog_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/sog_map_mem.sv
`timescale 1ns / 1ps
// Composite bitmap memory: one write port, two registered read ports.
module sog_map_mem import sog_pkg::*; #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [SOG_WORD_BITS-1:0] wdata,
	input  logic [AW-1:0]            raddr_a,
	input  logic [AW-1:0]            raddr_b,
	output logic [SOG_WORD_BITS-1:0] rdata_a,
	output logic [SOG_WORD_BITS-1:0] rdata_b
);

	logic [SOG_WORD_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// File: hdl/sog_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for build (clear, sieve, count) and pair query over the bitmap memory.
module sog_ctrl import sog_pkg::*; #(
	parameter int unsigned MAX_LIMIT = SOG_MAX_LIMIT,
	parameter int unsigned DEPTH     = (SOG_MAX_LIMIT + 63) / 64,
	parameter int unsigned AW        = 10
) (
	input  logic                     clk,
	input  logic                     arst_n,
	sog_stream_if.sink               item,
	sog_stream_if.source             result,
	output logic                     map_we,
	output logic [AW-1:0]            map_waddr,
	output logic [SOG_WORD_BITS-1:0] map_wdata,
	output logic [AW-1:0]            map_raddr_a,
	output logic [AW-1:0]            map_raddr_b,
	input  logic [SOG_WORD_BITS-1:0] map_rdata_a,
	input  logic [SOG_WORD_BITS-1:0] map_rdata_b
);

	localparam logic [SOG_FIELD_W-1:0] LIMIT_CAP =
		(MAX_LIMIT - 1 > 65535) ? 16'hFFFF : 16'(MAX_LIMIT - 1);
	localparam logic [AW-1:0] LAST_WORD = AW'(DEPTH - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_K_TEST,
		ST_K_CHECK,
		ST_M_TEST,
		ST_M_WRITE,
		ST_C_READ,
		ST_C_ADD,
		ST_Q_RUN,
		ST_DONE
	} state_t;

	state_t                   state_q;
	logic [SOG_FIELD_W-1:0]   limit_q;
	logic [SOG_FIELD_W-1:0]   built_q;
	logic [SOG_FIELD_W-1:0]   n_q;
	logic [SOG_K_W-1:0]       k_q;
	logic [SOG_FIELD_W:0]     j_q;
	logic [AW-1:0]            w_q;
	logic [SOG_FIELD_W-1:0]   x_q;
	logic [SOG_FIELD_W-1:0]   cnt_q;
	logic [SOG_FIELD_W-1:0]   last_q;
	result_t                  pend_q;
	result_t                  res_q;
	logic                     res_valid_q;
	logic                     v_s1;
	logic [SOG_FIELD_W-1:0]   x_s1;
	logic [4:0]               pa_s1;
	logic [4:0]               pb_s1;

	logic [2*SOG_K_W-1:0]     k_sq;
	logic [SOG_FIELD_W-2:0]   maxb;
	logic [AW-1:0]            last_w;
	logic [SOG_WORD_BITS-1:0] cmask;
	logic [5:0]               pc;
	logic [SOG_FIELD_W-1:0]   nx;
	logic                     issue;
	logic                     hit;
	logic                     q_ok;
	logic [SOG_FIELD_W-1:0]   cap_value;

	function automatic logic [AW-1:0] word_of(input logic [SOG_FIELD_W-1:0] n);
		word_of = AW'({{AW{1'b0}}, n[15:6]});
	endfunction

	assign k_sq   = k_q * k_q;
	assign maxb   = 15'((limit_q - 16'd1) >> 1);
	assign last_w = AW'({{AW{1'b0}}, maxb[14:5]});
	assign cmask  = ((w_q == '0) ? ~32'h1 : 32'hFFFF_FFFF)
		& ((w_q == last_w) ? (32'hFFFF_FFFF >> (5'd31 - maxb[4:0])) : 32'hFFFF_FFFF);
	assign pc     = 6'($countones(~map_rdata_a & cmask));
	assign nx     = n_q - x_q;
	assign issue  = x_q <= {1'b0, n_q[15:1]};
	assign hit    = v_s1 && !map_rdata_a[pa_s1] && !map_rdata_b[pb_s1];
	assign q_ok   = !item.data.value[0] && (item.data.value >= 16'(SOG_MIN_QUERY))
		&& (item.data.value <= built_q);
	assign cap_value = (item.data.value > LIMIT_CAP) ? LIMIT_CAP : item.data.value;

	assign item.ready   = (state_q == ST_IDLE);
	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	always_comb begin
		map_we      = 1'b0;
		map_waddr   = w_q;
		map_wdata   = '0;
		map_raddr_a = w_q;
		map_raddr_b = w_q;
		unique case (state_q)
			ST_CLEAR: begin
				map_we = 1'b1;
			end
			ST_K_TEST: begin
				map_raddr_a = word_of(16'(k_q));
			end
			ST_M_TEST: begin
				map_raddr_a = word_of(j_q[15:0]);
			end
			ST_M_WRITE: begin
				map_we    = 1'b1;
				map_waddr = word_of(j_q[15:0]);
				map_wdata = map_rdata_a | (32'h1 << j_q[5:1]);
			end
			ST_Q_RUN: begin
				map_raddr_a = word_of(x_q);
				map_raddr_b = word_of(nx);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			built_q     <= '0;
			v_s1        <= 1'b0;
		end else begin
			// drop the output once taken, unless the done state reloads it
			if (res_valid_q && result.ready && state_q != ST_DONE) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						if (item.data.kind == KIND_BUILD) begin
							pend_q  <= '0;
							limit_q <= cap_value;
							built_q <= cap_value;
							w_q     <= '0;
							state_q <= ST_CLEAR;
						end else if (q_ok) begin
							pend_q  <= '0;
							n_q     <= item.data.value;
							x_q     <= 16'(SOG_FIRST_ODD);
							cnt_q   <= '0;
							last_q  <= '0;
							v_s1    <= 1'b0;
							state_q <= ST_Q_RUN;
						end else begin
							pend_q  <= '{status: STATUS_INVALID, count: '0,
								smaller_addend: '0, larger_addend: '0};
							state_q <= ST_DONE;
						end
					end
				end
				ST_CLEAR: begin
					if (w_q == LAST_WORD) begin
						if (limit_q < 16'(SOG_FIRST_ODD)) begin
							pend_q.status <= STATUS_BUILT;
							state_q       <= ST_DONE;
						end else begin
							k_q     <= SOG_K_W'(SOG_FIRST_ODD);
							state_q <= ST_K_TEST;
						end
					end else begin
						w_q <= w_q + 1'b1;
					end
				end
				ST_K_TEST: begin
					if (k_sq > 18'(limit_q)) begin
						w_q     <= '0;
						cnt_q   <= '0;
						state_q <= ST_C_READ;
					end else begin
						state_q <= ST_K_CHECK;
					end
				end
				ST_K_CHECK: begin
					// skip k already struck out by a smaller prime
					if (map_rdata_a[k_q[5:1]]) begin
						k_q     <= k_q + 2'd2;
						state_q <= ST_K_TEST;
					end else begin
						j_q     <= 17'({k_q, 1'b0}) + 17'(k_q);
						state_q <= ST_M_TEST;
					end
				end
				ST_M_TEST: begin
					if (j_q > {1'b0, limit_q}) begin
						k_q     <= k_q + 2'd2;
						state_q <= ST_K_TEST;
					end else begin
						state_q <= ST_M_WRITE;
					end
				end
				ST_M_WRITE: begin
					j_q     <= j_q + 17'({k_q, 1'b0});
					state_q <= ST_M_TEST;
				end
				ST_C_READ: begin
					state_q <= ST_C_ADD;
				end
				ST_C_ADD: begin
					cnt_q <= cnt_q + 16'(pc);
					if (w_q == last_w) begin
						pend_q.status <= STATUS_BUILT;
						pend_q.count  <= cnt_q + 16'(pc);
						state_q       <= ST_DONE;
					end else begin
						w_q     <= w_q + 1'b1;
						state_q <= ST_C_READ;
					end
				end
				ST_Q_RUN: begin
					v_s1  <= issue;
					x_s1  <= x_q;
					pa_s1 <= x_q[5:1];
					pb_s1 <= nx[5:1];
					if (issue) begin
						x_q <= x_q + 16'd2;
					end
					if (hit) begin
						cnt_q  <= cnt_q + 16'd1;
						last_q <= x_s1;
					end
					// finish once the last pair has left the check stage
					if (!issue && !v_s1) begin
						if (cnt_q == '0) begin
							pend_q.status <= STATUS_NO_PAIR;
						end else begin
							pend_q.status         <= STATUS_PAIR;
							pend_q.count          <= cnt_q;
							pend_q.smaller_addend <= last_q;
							pend_q.larger_addend  <= n_q - last_q;
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!res_valid_q || result.ready) begin
						res_q       <= pend_q;
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hdl/odd_sieve_goldbach_engine_top.sv
`timescale 1ns / 1ps
// Odd-only sieve engine: one bitmap bit per odd number, a set bit marks a composite.
// A build item clears the bitmap (one word a cycle, (MAX_LIMIT+63)/64 words), sieves
// with every odd prime k up to sqrt(limit), testing each k and striking each multiple
// (read, then write back through the single write port), then counts the odd primes
// one 32-bit word at a time. A query for N reads the bits of x and N-x in the same
// cycle on the two read ports, one odd x per cycle; an invalid query is answered
// without a scan. One item is worked on at a time, and the next item is taken
// while the previous result still waits in the output register. The bitmap has no
// reset sweep: every query before the first build is rejected, and a build clears it.
module odd_sieve_goldbach_engine_top import sog_pkg::*; #(
	parameter int unsigned MAX_LIMIT = SOG_MAX_LIMIT
) (
	input  logic         clk,
	input  logic         arst_n,
	sog_stream_if.sink   item,
	sog_stream_if.source result
);

	localparam int unsigned DEPTH = (MAX_LIMIT + 63) / 64;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                     map_we;
	logic [AW-1:0]            map_waddr;
	logic [SOG_WORD_BITS-1:0] map_wdata;
	logic [AW-1:0]            map_raddr_a;
	logic [AW-1:0]            map_raddr_b;
	logic [SOG_WORD_BITS-1:0] map_rdata_a;
	logic [SOG_WORD_BITS-1:0] map_rdata_b;

	sog_ctrl #(
		.MAX_LIMIT (MAX_LIMIT),
		.DEPTH     (DEPTH),
		.AW        (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.result      (result),
		.map_we      (map_we),
		.map_waddr   (map_waddr),
		.map_wdata   (map_wdata),
		.map_raddr_a (map_raddr_a),
		.map_raddr_b (map_raddr_b),
		.map_rdata_a (map_rdata_a),
		.map_rdata_b (map_rdata_b)
	);

	sog_map_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_map (
		.clk     (clk),
		.we      (map_we),
		.waddr   (map_waddr),
		.wdata   (map_wdata),
		.raddr_a (map_raddr_a),
		.raddr_b (map_raddr_b),
		.rdata_a (map_rdata_a),
		.rdata_b (map_rdata_b)
	);

	a_no_write_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> !map_we)
		else $error("bitmap written while the engine is idle");

	a_pair_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.status == STATUS_PAIR |->
			result.data.smaller_addend[0] && result.data.larger_addend[0]
			&& result.data.smaller_addend <= result.data.larger_addend
			&& result.data.count != '0)
		else $error("reported pair is not two odd addends in order");

	a_no_pair_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.data.status == STATUS_NO_PAIR
			|| result.data.status == STATUS_INVALID) |->
			result.data.count == '0 && result.data.smaller_addend == '0
			&& result.data.larger_addend == '0)
		else $error("empty query result carries nonzero fields");

	a_build_zero_addends: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.status == STATUS_BUILT |->
			result.data.smaller_addend == '0 && result.data.larger_addend == '0)
		else $error("build result carries addends");

endmodule

// File: dv/odd_sieve_goldbach_engine_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the odd-only sieve and Goldbach pair engine.
module odd_sieve_goldbach_engine_top_tb;
	import sog_pkg::*;

	localparam int unsigned MAP_BITS   = SOG_MAX_LIMIT / 2;
	localparam int unsigned TOP_LIMIT  = SOG_MAX_LIMIT - 1;
	// A full build runs with no transfer at all.
	localparam int unsigned STALL_LIMIT = 400000;
	localparam int unsigned TAIL_CYCLES = 200;

	logic clk;
	logic arst_n;

	sog_stream_if #(.payload_t(item_t))   item_ch ();
	sog_stream_if #(.payload_t(result_t)) result_ch ();

	odd_sieve_goldbach_engine_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// Predictor state: one bit per odd number, set for a composite.
	bit          odd_composite [MAP_BITS];
	int unsigned sieve_top;

	result_t expected_results [$];
	int unsigned mismatches;
	int unsigned builds_sent, queries_sent, pairs_sent, rejects_sent;

	bit tx_idle_on;
	bit rx_idle_on;
	int unsigned rx_hold_cycles;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic bit is_composite(int unsigned n);
		int unsigned idx;
		idx = (n - 1) >> 1;
		if (idx >= MAP_BITS)
			return 1'b1;
		return odd_composite[idx];
	endfunction

	function automatic result_t sieve_build(logic [SOG_FIELD_W-1:0] value);
		result_t     res;
		int unsigned limit, primes;
		limit = 32'(value);
		primes = 0;
		if (limit > TOP_LIMIT)
			limit = TOP_LIMIT;
		foreach (odd_composite[i])
			odd_composite[i] = 1'b0;
		for (int unsigned k = SOG_FIRST_ODD; k * k <= limit; k += 2) begin
			if (!is_composite(k)) begin
				for (int unsigned j = 3 * k; j <= limit; j += 2 * k)
					odd_composite[(j - 1) >> 1] = 1'b1;
			end
		end
		for (int unsigned n = SOG_FIRST_ODD; n <= limit; n += 2)
			if (!is_composite(n))
				primes++;
		sieve_top = limit & 16'hFFFF;
		res = '0;
		res.status = STATUS_BUILT;
		res.count = primes[SOG_FIELD_W-1:0];
		return res;
	endfunction

	function automatic result_t goldbach_query(logic [SOG_FIELD_W-1:0] value);
		result_t     res;
		int unsigned n, pairs, best;
		n = 32'(value);
		pairs = 0;
		best = 0;
		res = '0;
		if (value[0] || n < SOG_MIN_QUERY || n > sieve_top) begin
			res.status = STATUS_INVALID;
			return res;
		end
		for (int unsigned x = SOG_FIRST_ODD; x <= n / 2; x += 2) begin
			if (!is_composite(x) && !is_composite(n - x)) begin
				pairs++;
				best = x;
			end
		end
		if (pairs == 0) begin
			res.status = STATUS_NO_PAIR;
			return res;
		end
		res.status = STATUS_PAIR;
		res.count = pairs[SOG_FIELD_W-1:0];
		res.smaller_addend = best[SOG_FIELD_W-1:0];
		res.larger_addend = 16'(n - best);
		return res;
	endfunction

	// Offer one item, wait for its transfer and record what it must produce.
	task automatic send_item(kind_t kind, logic [SOG_FIELD_W-1:0] value);
		item_t   itm;
		result_t want;
		int      gap;
		gap = tx_idle_on ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		itm.kind = kind;
		itm.value = value;
		item_ch.valid <= 1'b1;
		item_ch.data <= itm;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		if (kind == KIND_BUILD) begin
			want = sieve_build(value);
			builds_sent++;
		end else begin
			want = goldbach_query(value);
			queries_sent++;
			if (want.status == STATUS_PAIR)
				pairs_sent++;
			else if (want.status == STATUS_INVALID)
				rejects_sent++;
		end
		expected_results.push_back(want);
	endtask

	// Hold the input until every outstanding result has come back.
	task automatic wait_for_results();
		item_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_results.size() != 0);
	endtask

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : result_check
		result_t want;
		result_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			if (expected_results.size() == 0) begin
				$error("result: unexpected transfer, status %0d count %0d",
					got.status, got.count);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				check_field("status", want.status, got.status);
				check_field("count", want.count, got.count);
				check_field("smaller_addend", want.smaller_addend, got.smaller_addend);
				check_field("larger_addend", want.larger_addend, got.larger_addend);
			end
		end
	end

	// Result side: random stalls, plus a long hold-off when one is requested.
	initial begin : result_sink
		int unsigned gap;
		result_ch.ready <= 1'b0;
		forever begin
			gap = rx_idle_on ? $urandom_range(0, 8) : 0;
			if (rx_hold_cycles > 0) begin
				gap = rx_hold_cycles;
				rx_hold_cycles = 0;
			end
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid)
				@(posedge clk);
		end
	end

	initial begin : stall_watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic test_query_before_build();
		send_item(KIND_QUERY, 16'd6);
		send_item(KIND_QUERY, 16'd65534);
		send_item(KIND_QUERY, 16'd0);
		wait_for_results();
	endtask

	task automatic test_small_builds();
		send_item(KIND_BUILD, 16'd0);
		send_item(KIND_BUILD, 16'd1);
		send_item(KIND_BUILD, 16'd2);
		send_item(KIND_BUILD, 16'd3);
		// limit 3 is below the smallest valid query
		send_item(KIND_QUERY, 16'd6);
		send_item(KIND_BUILD, 16'd10);
		send_item(KIND_QUERY, 16'd6);
		send_item(KIND_QUERY, 16'd8);
		send_item(KIND_QUERY, 16'd10);
		send_item(KIND_QUERY, 16'd4);
		send_item(KIND_QUERY, 16'd7);
		send_item(KIND_QUERY, 16'd12);
		wait_for_results();
	endtask

	task automatic test_full_build();
		send_item(KIND_BUILD, 16'hFFFF);
		send_item(KIND_QUERY, 16'd65534);
		send_item(KIND_QUERY, 16'd65535);
		send_item(KIND_QUERY, 16'd65532);
		send_item(KIND_QUERY, 16'd32768);
		wait_for_results();
	endtask

	// Stall the result side long enough that the engine backs up its input.
	task automatic test_output_backpressure();
		logic [SOG_FIELD_W-1:0] v;
		send_item(KIND_BUILD, 16'd1000);
		wait_for_results();
		rx_hold_cycles = 400;
		for (int i = 0; i < 12; i++) begin
			if ($urandom_range(0, 1))
				v = 16'(2 * $urandom_range(3, 20));
			else
				v = 16'($urandom_range(0, 65535));
			send_item(KIND_QUERY, v);
		end
		wait_for_results();
	endtask

	task automatic run_random_items(int unsigned total);
		logic [SOG_FIELD_W-1:0] v;
		int unsigned hi, cap;
		for (int unsigned i = 0; i < total; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				// keep most builds short, a few span the whole range
				if ($urandom_range(0, 11) == 0)
					v = 16'($urandom_range(0, 65535));
				else
					v = 16'($urandom_range(0, 1 << $urandom_range(2, 12)));
				send_item(KIND_BUILD, v);
			end else begin
				cap = 1 << $urandom_range(3, 16);
				hi = (sieve_top < cap) ? sieve_top : cap;
				if ($urandom_range(0, 3) == 0 || hi < SOG_MIN_QUERY) begin
					v = 16'($urandom_range(0, 65535));
				end else if ($urandom_range(0, 7) == 0) begin
					// probe the edge of the built range
					v = 16'((sieve_top & 16'hFFFE) + 2 * $urandom_range(0, 1));
				end else begin
					v = 16'($urandom_range(SOG_MIN_QUERY, hi) & 16'hFFFE);
					if (v < SOG_MIN_QUERY)
						v = 16'(SOG_MIN_QUERY);
				end
				send_item(KIND_QUERY, v);
			end
		end
	endtask

	task automatic test_random_traffic();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		run_random_items(40);
		wait_for_results();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		run_random_items(20);
		wait_for_results();
		rx_idle_on = 1'b1;
		run_random_items(10);
		wait_for_results();
	endtask

	initial begin : main_sequence
		mismatches = 0;
		builds_sent = 0;
		queries_sent = 0;
		pairs_sent = 0;
		rejects_sent = 0;
		sieve_top = 0;
		rx_hold_cycles = 0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		foreach (odd_composite[i])
			odd_composite[i] = 1'b0;
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_query_before_build();
		test_small_builds();
		test_full_build();
		test_output_backpressure();
		test_random_traffic();

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d builds and %0d queries: %0d with a prime pair, %0d rejected.",
			builds_sent, queries_sent, pairs_sent, rejects_sent);
		$display("Output stalls, a long receiver hold-off and drained pauses were included.");
		if (mismatches == 0 && expected_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
